### hdl/skrt_pkg.sv
package skrt_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned QTY_W       = 32;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NAME_FULL_W = 3 * WORD_W + BYTE_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_SEARCH = 3'd2,
    OP_UPDATE = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // shared unit results: key order and saturated quantity sum
  typedef struct packed {
    logic                    lt;
    logic                    eq;
    logic signed [QTY_W-1:0] sum;
  } unit_res_t;

endpackage

### hdl/skrt_if.sv
interface skrt_req_if;
  import skrt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [KEY_W-1:0]         part_number;
  logic [WORD_W-1:0]        name_word0;
  logic [WORD_W-1:0]        name_word1;
  logic [WORD_W-1:0]        name_word2;
  logic [BYTE_W-1:0]        name_byte24;
  logic signed [QTY_W-1:0]  quantity;

  modport source (
    output valid, op, part_number, name_word0, name_word1, name_word2, name_byte24,
           quantity,
    input  ready
  );

  modport sink (
    input  valid, op, part_number, name_word0, name_word1, name_word2, name_byte24,
           quantity,
    output ready
  );
endinterface

interface skrt_rsp_if;
  import skrt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [KEY_W-1:0]         out_part_number;
  logic [WORD_W-1:0]        out_name_word0;
  logic [WORD_W-1:0]        out_name_word1;
  logic [WORD_W-1:0]        out_name_word2;
  logic [BYTE_W-1:0]        out_name_byte24;
  logic signed [QTY_W-1:0]  out_quantity;
  logic                     last;

  modport source (
    output valid, status, out_part_number, out_name_word0, out_name_word1,
           out_name_word2, out_name_byte24, out_quantity, last,
    input  ready
  );

  modport sink (
    input  valid, status, out_part_number, out_name_word0, out_name_word1,
           out_name_word2, out_name_byte24, out_quantity, last,
    output ready
  );
endinterface

### hdl/skrt_store.sv
module skrt_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned NAME_W = 200,
  parameter int unsigned AW     = 6
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic [skrt_pkg::KEY_W-1:0]         wkey_i,
  input  logic [NAME_W-1:0]                  wname_i,
  input  logic signed [skrt_pkg::QTY_W-1:0]  wqty_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic [skrt_pkg::KEY_W-1:0]         rkey_o,
  output logic [NAME_W-1:0]                  rname_o,
  output logic signed [skrt_pkg::QTY_W-1:0]  rqty_o
);
  import skrt_pkg::*;

  localparam int unsigned ENTRY_W = KEY_W + NAME_W + QTY_W;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wkey_i, wname_i, wqty_i};
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rkey_o  = rd_q[ENTRY_W-1 -: KEY_W];
  assign rname_o = rd_q[QTY_W +: NAME_W];
  assign rqty_o  = rd_q[QTY_W-1:0];

endmodule

### hdl/skrt_unit.sv
module skrt_unit (
  input  logic [skrt_pkg::KEY_W-1:0]         key_a_i,
  input  logic [skrt_pkg::KEY_W-1:0]         key_b_i,
  input  logic signed [skrt_pkg::QTY_W-1:0]  qty_a_i,
  input  logic signed [skrt_pkg::QTY_W-1:0]  qty_b_i,
  output skrt_pkg::unit_res_t                res_o
);
  import skrt_pkg::*;

  localparam logic signed [QTY_W-1:0] QTY_MAX = {1'b0, {(QTY_W-1){1'b1}}};
  localparam logic signed [QTY_W-1:0] QTY_MIN = {1'b1, {(QTY_W-1){1'b0}}};

  logic [QTY_W:0] sum_ext;

  assign sum_ext = {qty_a_i[QTY_W-1], qty_a_i} + {qty_b_i[QTY_W-1], qty_b_i};

  always_comb begin
    res_o.lt = key_a_i < key_b_i;
    res_o.eq = key_a_i == key_b_i;
    // overflow when the two top bits of the extended sum disagree
    if (sum_ext[QTY_W] != sum_ext[QTY_W-1]) begin
      res_o.sum = sum_ext[QTY_W] ? QTY_MIN : QTY_MAX;
    end else begin
      res_o.sum = sum_ext[QTY_W-1:0];
    end
  end

endmodule

### hdl/sorted_key_record_table.sv
// Channel  Dir  Modport  Payload
// req_i    in   sink     op, part_number, name_word0..2, name_byte24, quantity
// rsp_o    out  source   status, out_part_number, out_name_word0..2,
//                        out_name_byte24, out_quantity, last
//
// One request at a time; req_i.ready is high only while idle.
// Lookup reads entry 0 up to the first key not below the request, one read and
// one compare per entry, then decides. Results are held until rsp_o takes them.
// Insert/erase then move each later entry one slot, a read then a write per entry
// (one write port, registered read); insert then writes the new entry.
// List sends one record at a time. Reset empties the table at once.
module sorted_key_record_table #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned NAME_BYTES = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skrt_req_if.sink   req_i,
  skrt_rsp_if.source rsp_o
);
  import skrt_pkg::*;

  localparam int unsigned NAME_W = NAME_BYTES * BYTE_W;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SCAN_RD  = 10'b00_0000_0010,
    S_SCAN_CMP = 10'b00_0000_0100,
    S_EXEC     = 10'b00_0000_1000,
    S_SHIFT_RD = 10'b00_0001_0000,
    S_SHIFT_WR = 10'b00_0010_0000,
    S_INS_WR   = 10'b00_0100_0000,
    S_LIST_RD  = 10'b00_1000_0000,
    S_LIST_LD  = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // control
  logic [CW-1:0] cnt_q, cnt_d;   // stored entries
  logic [CW-1:0] pos_q, pos_d;   // lower-bound position of the key
  logic [CW-1:0] sh_q, sh_d;     // move cursor
  logic [CW-1:0] li_q, li_d;     // list cursor
  logic          found_q, found_d;

  // latched request
  op_e                     req_op_q, req_op_d;
  logic [KEY_W-1:0]        req_key_q, req_key_d;
  logic [NAME_W-1:0]       req_name_q, req_name_d;
  logic signed [QTY_W-1:0] req_qty_q, req_qty_d;

  // record found by the lookup
  logic [KEY_W-1:0]        rec_key_q, rec_key_d;
  logic [NAME_W-1:0]       rec_name_q, rec_name_d;
  logic signed [QTY_W-1:0] rec_qty_q, rec_qty_d;

  // result register
  status_e                 res_status_q, res_status_d;
  logic [KEY_W-1:0]        res_key_q, res_key_d;
  logic [NAME_W-1:0]       res_name_q, res_name_d;
  logic signed [QTY_W-1:0] res_qty_q, res_qty_d;
  logic                    res_last_q, res_last_d;

  // store port
  logic                    mem_we;
  logic [CW-1:0]           mem_widx, mem_ridx;
  logic [KEY_W-1:0]        mem_wkey, rd_key;
  logic [NAME_W-1:0]       mem_wname, rd_name;
  logic signed [QTY_W-1:0] mem_wqty, rd_qty;

  unit_res_t               unit_res;
  logic [NAME_FULL_W-1:0]  name_in_full, name_out_full;
  logic [CW-1:0]           sh_dn, sh_up;
  logic                    is_ins;

  skrt_store #(
    .DEPTH  (DEPTH),
    .NAME_W (NAME_W),
    .AW     (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_widx[AW-1:0]),
    .wkey_i  (mem_wkey),
    .wname_i (mem_wname),
    .wqty_i  (mem_wqty),
    .raddr_i (mem_ridx[AW-1:0]),
    .rkey_o  (rd_key),
    .rname_o (rd_name),
    .rqty_o  (rd_qty)
  );

  // stored key vs requested key; saturating add of found qty and change
  skrt_unit u_unit (
    .key_a_i (rd_key),
    .key_b_i (req_key_q),
    .qty_a_i (rec_qty_q),
    .qty_b_i (req_qty_q),
    .res_o   (unit_res)
  );

  // bytes beyond NAME_BYTES are never stored and read back as zero
  assign name_in_full = {req_i.name_byte24, req_i.name_word2, req_i.name_word1,
                         req_i.name_word0};
  assign name_out_full = NAME_FULL_W'(res_name_q);

  assign sh_dn  = sh_q - ONE;
  assign sh_up  = sh_q + ONE;
  assign is_ins = req_op_q == OP_INSERT;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    sh_d         = sh_q;
    li_d         = li_q;
    found_d      = found_q;
    req_op_d     = req_op_q;
    req_key_d    = req_key_q;
    req_name_d   = req_name_q;
    req_qty_d    = req_qty_q;
    rec_key_d    = rec_key_q;
    rec_name_d   = rec_name_q;
    rec_qty_d    = rec_qty_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_name_d   = res_name_q;
    res_qty_d    = res_qty_q;
    res_last_d   = res_last_q;
    mem_we       = 1'b0;
    mem_widx     = sh_q;
    mem_ridx     = pos_q;
    mem_wkey     = rd_key;
    mem_wname    = rd_name;
    mem_wqty     = rd_qty;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_op_d   = op_e'(req_i.op);
          req_key_d  = req_i.part_number;
          req_name_d = name_in_full[NAME_W-1:0];
          req_qty_d  = req_i.quantity;
          pos_d      = '0;
          li_d       = '0;
          case (op_e'(req_i.op))
            OP_LIST: begin
              if (cnt_q == '0) begin
                res_status_d = ST_EMPTY;
                res_key_d    = '0;
                res_name_d   = '0;
                res_qty_d    = '0;
                res_last_d   = 1'b1;
                state_d      = S_OUT;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            OP_INSERT, OP_ERASE, OP_SEARCH, OP_UPDATE: state_d = S_SCAN_RD;
            default: state_d = S_IDLE;  // undefined ops produce nothing
          endcase
        end
      end

      // linear lower-bound search, one entry per read/compare pair
      S_SCAN_RD: begin
        if (pos_q == cnt_q) begin
          found_d = 1'b0;
          state_d = S_EXEC;
        end else begin
          mem_ridx = pos_q;
          state_d  = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        rec_key_d  = rd_key;
        rec_name_d = rd_name;
        rec_qty_d  = rd_qty;
        if (unit_res.lt) begin
          pos_d   = pos_q + ONE;
          state_d = S_SCAN_RD;
        end else begin
          found_d = unit_res.eq;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        // error result by default: requested key, zero payload
        res_status_d = ST_NOT_FOUND;
        res_key_d    = req_key_q;
        res_name_d   = '0;
        res_qty_d    = '0;
        res_last_d   = 1'b1;
        state_d      = S_OUT;
        case (req_op_q)
          OP_INSERT: begin
            if (found_q) begin
              res_status_d = ST_EXISTS;
            end else if (cnt_q == DEPTH_C) begin
              res_status_d = ST_FULL;
            end else if (pos_q == cnt_q) begin
              state_d = S_INS_WR;
            end else begin
              sh_d    = cnt_q;
              state_d = S_SHIFT_RD;
            end
          end
          OP_ERASE: begin
            if (found_q) begin
              res_status_d = ST_OK;
              res_name_d   = rec_name_q;
              res_qty_d    = rec_qty_q;
              if (pos_q + ONE == cnt_q) begin
                cnt_d = cnt_q - ONE;
              end else begin
                sh_d    = pos_q + ONE;
                state_d = S_SHIFT_RD;
              end
            end
          end
          OP_SEARCH: begin
            if (found_q) begin
              res_status_d = ST_OK;
              res_name_d   = rec_name_q;
              res_qty_d    = rec_qty_q;
            end
          end
          OP_UPDATE: begin
            if (found_q) begin
              mem_we       = 1'b1;
              mem_widx     = pos_q;
              mem_wkey     = rec_key_q;
              mem_wname    = rec_name_q;
              mem_wqty     = unit_res.sum;
              res_status_d = ST_OK;
              res_name_d   = rec_name_q;
              res_qty_d    = unit_res.sum;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      // insert moves entries up from the tail, erase moves them down
      S_SHIFT_RD: begin
        mem_ridx = is_ins ? sh_dn : sh_q;
        state_d  = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we   = 1'b1;
        mem_widx = is_ins ? sh_q : sh_dn;
        if (is_ins) begin
          if (sh_dn == pos_q) begin
            state_d = S_INS_WR;
          end else begin
            sh_d    = sh_dn;
            state_d = S_SHIFT_RD;
          end
        end else begin
          if (sh_up == cnt_q) begin
            cnt_d   = cnt_q - ONE;
            state_d = S_OUT;
          end else begin
            sh_d    = sh_up;
            state_d = S_SHIFT_RD;
          end
        end
      end

      S_INS_WR: begin
        mem_we       = 1'b1;
        mem_widx     = pos_q;
        mem_wkey     = req_key_q;
        mem_wname    = req_name_q;
        mem_wqty     = req_qty_q;
        cnt_d        = cnt_q + ONE;
        res_status_d = ST_OK;
        res_key_d    = req_key_q;
        res_name_d   = req_name_q;
        res_qty_d    = req_qty_q;
        res_last_d   = 1'b1;
        state_d      = S_OUT;
      end

      S_LIST_RD: begin
        mem_ridx = li_q;
        state_d  = S_LIST_LD;
      end

      S_LIST_LD: begin
        res_status_d = ST_OK;
        res_key_d    = rd_key;
        res_name_d   = rd_name;
        res_qty_d    = rd_qty;
        res_last_d   = (li_q + ONE) == cnt_q;
        state_d      = S_OUT;
      end

      // hold the result until the transfer on rsp_o
      S_OUT: begin
        if (rsp_o.ready) begin
          if (req_op_q == OP_LIST && !res_last_q) begin
            li_d    = li_q + ONE;
            state_d = S_LIST_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      sh_q    <= '0;
      li_q    <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      sh_q    <= sh_d;
      li_q    <= li_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_op_q     <= req_op_d;
    req_key_q    <= req_key_d;
    req_name_q   <= req_name_d;
    req_qty_q    <= req_qty_d;
    rec_key_q    <= rec_key_d;
    rec_name_q   <= rec_name_d;
    rec_qty_q    <= rec_qty_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_name_q   <= res_name_d;
    res_qty_q    <= res_qty_d;
    res_last_q   <= res_last_d;
  end

  assign req_i.ready = state_q == S_IDLE;

  assign rsp_o.valid           = state_q == S_OUT;
  assign rsp_o.status          = res_status_q;
  assign rsp_o.out_part_number = res_key_q;
  assign rsp_o.out_name_word0  = name_out_full[WORD_W-1:0];
  assign rsp_o.out_name_word1  = name_out_full[2*WORD_W-1:WORD_W];
  assign rsp_o.out_name_word2  = name_out_full[3*WORD_W-1:2*WORD_W];
  assign rsp_o.out_name_byte24 = name_out_full[NAME_FULL_W-1:3*WORD_W];
  assign rsp_o.out_quantity    = res_qty_q;
  assign rsp_o.last            = res_last_q;

endmodule
